/* hw/rtl/fqs_pkg.sv */
// Package for the searchable FIFO queue: operation and status codes,
// transaction structs, controller states and the cell control group.
// No dependencies.
`default_nettype none

package fqs_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [4:0]         found_position;
        logic [4:0]         occupancy;
        t_status            status;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_FIND
    } t_state;

    typedef struct packed {
        logic push;
        logic shift;
        logic rotate;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hw/rtl/fqs_cell.sv */
// One storage cell of the queue chain; cell INDEX holds the entry at
// position INDEX from the head. Depends on fqs_pkg.
`default_nettype none

module fqs_cell #(
    parameter int unsigned CW    = 5,
    parameter int unsigned INDEX = 0
) (
    input  wire logic                 i_clk,
    input  wire fqs_pkg::t_cell_ctl   i_ctl,
    input  wire logic [CW-1:0]        i_count,
    input  wire logic signed [31:0]   i_push_value,
    input  wire logic signed [31:0]   i_next_value,
    input  wire logic signed [31:0]   i_head_value,
    output logic signed [31:0]        o_value
);
    import fqs_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_is_tail;
    logic               w_is_last;

    assign w_is_tail = (i_count == CW'(INDEX));
    assign w_is_last = (i_count == CW'(INDEX + 1));

    always_comb begin
        n_value = r_value;
        if (i_ctl.push && w_is_tail) begin
            n_value = i_push_value;
        end else if (i_ctl.shift) begin
            n_value = i_next_value;
        end else if (i_ctl.rotate) begin
            n_value = w_is_last ? i_head_value : i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

/* hw/rtl/fifo_queue_with_search_top.sv */
// Top level of the searchable FIFO queue: controller, output buffer and
// the chain of fqs_cell storage cells. Depends on fqs_pkg and fqs_cell.
//
// Input channel i_in_valid / o_in_stall / i_in_data carries one operation
// per transaction: push, pop, find or clear. Output channel o_out_valid /
// i_out_stall / o_out_data returns exactly one result per operation, in
// order. Entries sit in a chain of DEPTH cells, head in cell 0; a pop
// shifts the chain one cell toward the head.
// Push, pop and clear complete when accepted; their result is registered
// into the output buffer. Find rotates the whole occupied chain through
// cell 0, where the single comparator sits: it holds the input until the
// rotation ends (not at all on an empty queue), its result enters the
// output buffer once the last stored entry is compared, and the queue is
// back in order when it ends.
// A two-slot output buffer lets one new operation be accepted while a
// result waits; with both slots full, o_in_stall holds until the receiver
// lowers i_out_stall. Reset empties the queue and the output buffer; cell
// contents are not reset and are never read before being written.
`default_nettype none

module fifo_queue_with_search_top #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire fqs_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output fqs_pkg::t_out_item       o_out_data
);
    import fqs_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_step, n_step;
    logic [CW-1:0]      r_found, n_found;
    logic signed [31:0] r_key, n_key;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic               r_pend_valid, n_pend_valid;
    t_out_item          r_pend, n_pend;

    t_cell_ctl          w_ctl;
    logic               w_accept;
    logic               w_res_valid;
    t_out_item          w_res;
    logic               w_out_free;
    logic [CW-1:0]      w_found_now;
    logic signed [31:0] w_head;
    logic signed [31:0] w_cell_value [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic signed [31:0] w_next;
            if (k == DEPTH - 1) begin : g_end
                assign w_next = w_cell_value[k];
            end else begin : g_mid
                assign w_next = w_cell_value[k+1];
            end
            fqs_cell #(
                .CW    (CW),
                .INDEX (k)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_count      (r_count),
                .i_push_value (i_in_data.value),
                .i_next_value (w_next),
                .i_head_value (w_head),
                .o_value      (w_cell_value[k])
            );
        end
    endgenerate

    assign w_head     = w_cell_value[0];
    assign o_in_stall = (r_state != ST_IDLE) || r_pend_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_found_now = ((r_found == '0) && (w_head == r_key)) ? (r_step + CW'(1)) : r_found;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_found     = r_found;
        n_key       = r_key;
        w_ctl       = '0;
        w_res_valid = 1'b0;
        w_res       = '0;
        w_res.status = STAT_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_data.op)
                        OP_PUSH: begin
                            w_res_valid = 1'b1;
                            if (r_count >= CW'(DEPTH)) begin
                                w_res.status = STAT_FULL;
                            end else begin
                                w_ctl.push = 1'b1;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            w_res_valid = 1'b1;
                            if (r_count == '0) begin
                                w_res.status = STAT_EMPTY;
                            end else begin
                                w_ctl.shift        = 1'b1;
                                w_res.popped_value = w_head;
                                n_count            = r_count - CW'(1);
                            end
                        end
                        OP_FIND: begin
                            n_key   = i_in_data.value;
                            n_found = '0;
                            n_step  = '0;
                            if (r_count == '0) begin
                                w_res_valid = 1'b1;
                            end else begin
                                n_state = ST_FIND;
                            end
                        end
                        OP_CLEAR: begin
                            w_res_valid = 1'b1;
                            n_count     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIND: begin
                w_ctl.rotate = 1'b1;
                n_found      = w_found_now;
                n_step       = r_step + CW'(1);
                if (r_step == r_count - CW'(1)) begin
                    w_res_valid          = 1'b1;
                    w_res.found_position = 5'(w_found_now);
                    n_state              = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        w_res.occupancy = 5'(n_count);
    end

    // two-slot output buffer: output register plus pending slot
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (w_out_free) begin
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_out_valid  = 1'b1;
                n_pend       = w_res;
                n_pend_valid = w_res_valid;
            end else begin
                n_out        = w_res;
                n_out_valid  = w_res_valid;
                n_pend_valid = 1'b0;
            end
        end else if (w_res_valid) begin
            n_pend       = w_res;
            n_pend_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_found <= n_found;
        r_key   <= n_key;
        r_out   <= n_out;
        r_pend  <= n_pend;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("pending result without occupied output register");

    a_find_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND) |-> (r_step < r_count))
        else $error("find rotation ran past the stored entries");

    a_find_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND) |=> (r_count == $past(r_count)))
        else $error("count changed during find");

endmodule

`default_nettype wire
